@@ rtl/slsd_pkg.sv @@
// ----------------------------------------------------------------------------
// slsd_pkg: shared types and constants for the ordered key list
// Field widths, command and status codes, and the microcode control word
// that the sequencer hands to the datapath each step.
// ----------------------------------------------------------------------------
package slsd_pkg;

   // list geometry
   localparam int CAPACITY = 8;
   localparam int IDX_W    = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
   localparam int CNT_W    = $clog2(CAPACITY + 1);

   // beat field widths
   localparam int KIND_W   = 3;
   localparam int KEY_W    = 32;
   localparam int STATUS_W = 2;
   localparam int POS_W    = 3;
   localparam int FILL_W   = 4;
   localparam int RSP_FIELDS_W = STATUS_W + POS_W + KEY_W + FILL_W;
   localparam int RSP_DATA_W   = ((RSP_FIELDS_W + 7) / 8) * 8;

   // command codes carried in the request tuser
   localparam logic [KIND_W-1:0] KIND_CLEAR  = 3'd0;
   localparam logic [KIND_W-1:0] KIND_INSERT = 3'd1;
   localparam logic [KIND_W-1:0] KIND_SEARCH = 3'd2;
   localparam logic [KIND_W-1:0] KIND_REMOVE = 3'd3;
   localparam logic [KIND_W-1:0] KIND_DUMP   = 3'd4;

   // microcode address width
   localparam int UPC_W = 4;

   typedef logic [UPC_W-1:0] upc_type;

   typedef enum logic [STATUS_W-1:0] {
      ST_OK      = 2'd0,
      ST_FULL    = 2'd1,
      ST_EMPTY   = 2'd2,
      ST_MISSING = 2'd3
   } status_type;

   // branch conditions
   typedef enum logic [2:0] {
      COND_NONE   = 3'd0,
      COND_FULL   = 3'd1,
      COND_EMPTY  = 3'd2,
      COND_MATCH  = 3'd3,
      COND_END    = 3'd4,
      COND_SEARCH = 3'd5
   } cond_type;

   typedef enum logic [1:0] {
      POS_ZERO  = 2'd0,
      POS_SAVED = 2'd1,
      POS_INDEX = 2'd2
   } pos_sel_type;

   typedef enum logic [1:0] {
      CNT_HOLD  = 2'd0,
      CNT_CLEAR = 2'd1,
      CNT_INC   = 2'd2,
      CNT_DEC   = 2'd3
   } cnt_op_type;

   typedef enum logic [1:0] {
      WR_NONE  = 2'd0,
      WR_TAIL  = 2'd1,
      WR_SHIFT = 2'd2
   } wr_op_type;

   // one microcode word
   typedef struct packed {
      logic        dispatch;   // wait for a request beat and branch on its kind
      cond_type    cond_a;     // first branch, highest priority
      upc_type     tgt_a;
      cond_type    cond_b;     // second branch
      upc_type     tgt_b;
      upc_type     next;       // taken when neither branch fires
      logic        guard;      // datapath actions only on the fall-through path
      logic        emit;       // load the result register
      status_type  status;
      pos_sel_type pos_sel;
      logic        val_entry;  // result value is the entry at the index
      logic        last_end;   // tlast only when the index is the last entry
      cnt_op_type  cnt_op;
      logic        idx_inc;
      wr_op_type   wr_op;
      logic        pos_latch;  // save the index as the found position
   } ctl_word_type;

   // sequencer to datapath
   typedef struct packed {
      ctl_word_type ctl;
      logic         load;      // request beat accepted this cycle
      logic         go;        // step is not stalled by the result register
      logic         fire;      // guarded datapath actions take effect
   } act_type;

   // datapath to sequencer
   typedef struct packed {
      logic full;
      logic empty;
      logic match;
      logic at_end;
      logic is_search;
      logic out_busy;
   } flags_type;

endpackage

@@ rtl/slsd_sequencer.sv @@
// ----------------------------------------------------------------------------
// slsd_sequencer: microcode store and step counter
// Holds the control program, evaluates branch conditions from the datapath
// and steps the microcode address, stalling while a result cannot be loaded.
// ----------------------------------------------------------------------------
module slsd_sequencer (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_tvalid,
   input  logic [slsd_pkg::KIND_W-1:0]     req_kind,
   input  slsd_pkg::flags_type             flags,
   output logic                            req_ready,
   output slsd_pkg::act_type               act
);

   // microcode addresses
   localparam slsd_pkg::upc_type UA_IDLE   = 4'd0;
   localparam slsd_pkg::upc_type UA_CLR    = 4'd1;
   localparam slsd_pkg::upc_type UA_INS    = 4'd2;
   localparam slsd_pkg::upc_type UA_SRCH   = 4'd3;
   localparam slsd_pkg::upc_type UA_LOOP   = 4'd4;
   localparam slsd_pkg::upc_type UA_FOUND  = 4'd5;
   localparam slsd_pkg::upc_type UA_SHIFT  = 4'd6;
   localparam slsd_pkg::upc_type UA_DUMP0  = 4'd7;
   localparam slsd_pkg::upc_type UA_DUMP1  = 4'd8;
   localparam slsd_pkg::upc_type UA_E_OK   = 4'd9;
   localparam slsd_pkg::upc_type UA_E_FULL = 4'd10;
   localparam slsd_pkg::upc_type UA_E_EMPT = 4'd11;
   localparam slsd_pkg::upc_type UA_E_MISS = 4'd12;
   localparam slsd_pkg::upc_type UA_E_POS  = 4'd13;

   // control program
   function automatic slsd_pkg::ctl_word_type ucode_rom(input slsd_pkg::upc_type addr);
      slsd_pkg::ctl_word_type w;
      w         = '0;
      w.next    = UA_IDLE;
      w.status  = slsd_pkg::ST_OK;
      w.pos_sel = slsd_pkg::POS_ZERO;
      w.cnt_op  = slsd_pkg::CNT_HOLD;
      w.wr_op   = slsd_pkg::WR_NONE;
      w.cond_a  = slsd_pkg::COND_NONE;
      w.cond_b  = slsd_pkg::COND_NONE;
      case (addr)
         UA_IDLE: begin
            w.dispatch = 1'b1;
         end
         UA_CLR: begin
            w.cnt_op = slsd_pkg::CNT_CLEAR;
            w.next   = UA_E_OK;
         end
         UA_INS: begin
            // append unless full
            w.cond_a = slsd_pkg::COND_FULL;
            w.tgt_a  = UA_E_FULL;
            w.guard  = 1'b1;
            w.wr_op  = slsd_pkg::WR_TAIL;
            w.cnt_op = slsd_pkg::CNT_INC;
            w.next   = UA_E_OK;
         end
         UA_SRCH: begin
            w.cond_a = slsd_pkg::COND_EMPTY;
            w.tgt_a  = UA_E_EMPT;
            w.next   = UA_LOOP;
         end
         UA_LOOP: begin
            // compare one entry a step
            w.cond_a  = slsd_pkg::COND_MATCH;
            w.tgt_a   = UA_FOUND;
            w.cond_b  = slsd_pkg::COND_END;
            w.tgt_b   = UA_E_MISS;
            w.guard   = 1'b1;
            w.idx_inc = 1'b1;
            w.next    = UA_LOOP;
         end
         UA_FOUND: begin
            w.pos_latch = 1'b1;
            w.cond_a    = slsd_pkg::COND_SEARCH;
            w.tgt_a     = UA_E_POS;
            w.next      = UA_SHIFT;
         end
         UA_SHIFT: begin
            w.wr_op  = slsd_pkg::WR_SHIFT;
            w.cnt_op = slsd_pkg::CNT_DEC;
            w.next   = UA_E_POS;
         end
         UA_DUMP0: begin
            w.cond_a = slsd_pkg::COND_EMPTY;
            w.tgt_a  = UA_E_EMPT;
            w.next   = UA_DUMP1;
         end
         UA_DUMP1: begin
            // one result beat per entry
            w.emit      = 1'b1;
            w.pos_sel   = slsd_pkg::POS_INDEX;
            w.val_entry = 1'b1;
            w.last_end  = 1'b1;
            w.cond_a    = slsd_pkg::COND_END;
            w.tgt_a     = UA_IDLE;
            w.guard     = 1'b1;
            w.idx_inc   = 1'b1;
            w.next      = UA_DUMP1;
         end
         UA_E_OK: begin
            w.emit = 1'b1;
         end
         UA_E_FULL: begin
            w.emit   = 1'b1;
            w.status = slsd_pkg::ST_FULL;
         end
         UA_E_EMPT: begin
            w.emit   = 1'b1;
            w.status = slsd_pkg::ST_EMPTY;
         end
         UA_E_MISS: begin
            w.emit   = 1'b1;
            w.status = slsd_pkg::ST_MISSING;
         end
         UA_E_POS: begin
            w.emit    = 1'b1;
            w.pos_sel = slsd_pkg::POS_SAVED;
         end
         default: begin
            w.next = UA_IDLE;
         end
      endcase
      return w;
   endfunction

   // entry point per command; unknown commands are dropped
   function automatic slsd_pkg::upc_type dispatch_target(input logic [slsd_pkg::KIND_W-1:0] k);
      slsd_pkg::upc_type t;
      case (k)
         slsd_pkg::KIND_CLEAR:  t = UA_CLR;
         slsd_pkg::KIND_INSERT: t = UA_INS;
         slsd_pkg::KIND_SEARCH: t = UA_SRCH;
         slsd_pkg::KIND_REMOVE: t = UA_SRCH;
         slsd_pkg::KIND_DUMP:   t = UA_DUMP0;
         default:               t = UA_IDLE;
      endcase
      return t;
   endfunction

   function automatic logic cond_true(input slsd_pkg::cond_type c,
                                      input slsd_pkg::flags_type f);
      logic r;
      case (c)
         slsd_pkg::COND_FULL:   r = f.full;
         slsd_pkg::COND_EMPTY:  r = f.empty;
         slsd_pkg::COND_MATCH:  r = f.match;
         slsd_pkg::COND_END:    r = f.at_end;
         slsd_pkg::COND_SEARCH: r = f.is_search;
         default:               r = 1'b0;
      endcase
      return r;
   endfunction

   slsd_pkg::upc_type      upc_ff, upc_in;
   slsd_pkg::ctl_word_type ctl;
   logic                   jump_a, jump_b, go, load;

   // branch and stall decisions
   always_comb begin
      ctl    = ucode_rom(upc_ff);
      jump_a = cond_true(ctl.cond_a, flags);
      jump_b = cond_true(ctl.cond_b, flags);
      go     = !(ctl.emit && flags.out_busy);
      load   = ctl.dispatch && req_tvalid;
      if (ctl.dispatch) begin
         upc_in = load ? dispatch_target(req_kind) : UA_IDLE;
      end else if (!go) begin
         upc_in = upc_ff;
      end else if (jump_a) begin
         upc_in = ctl.tgt_a;
      end else if (jump_b) begin
         upc_in = ctl.tgt_b;
      end else begin
         upc_in = ctl.next;
      end
   end

   assign req_ready = ctl.dispatch;
   assign act.ctl   = ctl;
   assign act.load  = load;
   assign act.go    = go;
   assign act.fire  = go && !ctl.dispatch && (!ctl.guard || !(jump_a || jump_b));

   // step counter
   always_ff @(posedge clock) begin
      if (reset) begin
         upc_ff <= UA_IDLE;
      end else begin
         upc_ff <= upc_in;
      end
   end

endmodule

@@ rtl/slsd_datapath.sv @@
// ----------------------------------------------------------------------------
// slsd_datapath: entry registers, count, index and result register
// Executes the actions of each microcode word and reports the flags that
// the sequencer branches on.
// ----------------------------------------------------------------------------
module slsd_datapath (
   input  logic                                clock,
   input  logic                                reset,
   input  slsd_pkg::act_type                   act,
   input  logic [slsd_pkg::KIND_W-1:0]         req_kind,
   input  logic [slsd_pkg::KEY_W-1:0]          req_key,
   input  logic                                rsp_tready,
   output slsd_pkg::flags_type                 flags,
   output logic                                rsp_tvalid,
   output logic [slsd_pkg::RSP_DATA_W-1:0]     rsp_tdata,
   output logic                                rsp_tlast
);

   logic [slsd_pkg::KIND_W-1:0]  kind_ff;
   logic [slsd_pkg::KEY_W-1:0]   key_ff;
   logic [slsd_pkg::IDX_W-1:0]   idx_ff, idx_in;
   logic [slsd_pkg::IDX_W-1:0]   pos_ff;
   logic [slsd_pkg::CNT_W-1:0]   count_ff, count_in;
   logic [slsd_pkg::KEY_W-1:0]   entries_ff [slsd_pkg::CAPACITY];
   logic [slsd_pkg::KEY_W-1:0]   entries_in [slsd_pkg::CAPACITY];
   logic [slsd_pkg::KEY_W-1:0]   rd_cur;

   logic                         rsp_valid_ff, rsp_valid_in;
   logic [slsd_pkg::STATUS_W-1:0] rsp_status_ff;
   logic [slsd_pkg::POS_W-1:0]   rsp_pos_ff, rsp_pos_in;
   logic [slsd_pkg::KEY_W-1:0]   rsp_value_ff;
   logic [slsd_pkg::FILL_W-1:0]  rsp_fill_ff;
   logic                         rsp_last_ff;

   logic wr_tail, wr_shift, emit;

   assign rd_cur   = entries_ff[idx_ff];
   assign wr_tail  = act.fire && (act.ctl.wr_op == slsd_pkg::WR_TAIL);
   assign wr_shift = act.fire && (act.ctl.wr_op == slsd_pkg::WR_SHIFT);
   assign emit     = act.go && act.ctl.emit;

   // status flags for branching
   assign flags.full      = (count_ff == slsd_pkg::CNT_W'(slsd_pkg::CAPACITY));
   assign flags.empty     = (count_ff == '0);
   assign flags.match     = (rd_cur == key_ff);
   assign flags.at_end    = ((slsd_pkg::CNT_W'(idx_ff) + slsd_pkg::CNT_W'(1)) == count_ff);
   assign flags.is_search = (kind_ff == slsd_pkg::KIND_SEARCH);
   assign flags.out_busy  = rsp_valid_ff && !rsp_tready;

   // entry lanes: tail write or shift down above the removed slot
   for (genvar j = 0; j < slsd_pkg::CAPACITY; j++) begin : g_lane
      logic tail_hit, shift_hit;
      assign tail_hit = wr_tail &&
         (count_ff[slsd_pkg::IDX_W-1:0] == slsd_pkg::IDX_W'(j));
      if (j < slsd_pkg::CAPACITY - 1) begin : g_shift
         assign shift_hit = wr_shift && (pos_ff <= slsd_pkg::IDX_W'(j)) &&
            (slsd_pkg::CNT_W'(j + 1) < count_ff);
         always_comb begin
            if (tail_hit) begin
               entries_in[j] = key_ff;
            end else if (shift_hit) begin
               entries_in[j] = entries_ff[j+1];
            end else begin
               entries_in[j] = entries_ff[j];
            end
         end
      end else begin : g_top
         assign shift_hit = 1'b0;
         always_comb begin
            if (tail_hit || shift_hit) begin
               entries_in[j] = key_ff;
            end else begin
               entries_in[j] = entries_ff[j];
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      entries_ff <= entries_in;
   end

   // count and index updates
   always_comb begin
      count_in = count_ff;
      if (act.fire) begin
         case (act.ctl.cnt_op)
            slsd_pkg::CNT_CLEAR: count_in = '0;
            slsd_pkg::CNT_INC:   count_in = count_ff + slsd_pkg::CNT_W'(1);
            slsd_pkg::CNT_DEC:   count_in = count_ff - slsd_pkg::CNT_W'(1);
            default:             count_in = count_ff;
         endcase
      end
      idx_in = idx_ff;
      if (act.load) begin
         idx_in = '0;
      end else if (act.fire && act.ctl.idx_inc) begin
         idx_in = idx_ff + slsd_pkg::IDX_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
         idx_ff   <= '0;
      end else begin
         count_ff <= count_in;
         idx_ff   <= idx_in;
      end
   end

   // latched request beat and found position
   always_ff @(posedge clock) begin
      if (act.load) begin
         kind_ff <= req_kind;
         key_ff  <= req_key;
      end
      if (act.go && act.ctl.pos_latch) begin
         pos_ff <= idx_ff;
      end
   end

   // result register
   always_comb begin
      case (act.ctl.pos_sel)
         slsd_pkg::POS_SAVED: rsp_pos_in = slsd_pkg::POS_W'(pos_ff);
         slsd_pkg::POS_INDEX: rsp_pos_in = slsd_pkg::POS_W'(idx_ff);
         default:             rsp_pos_in = '0;
      endcase
      if (emit) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (emit) begin
         rsp_status_ff <= act.ctl.status;
         rsp_pos_ff    <= rsp_pos_in;
         rsp_value_ff  <= act.ctl.val_entry ? rd_cur : '0;
         rsp_fill_ff   <= slsd_pkg::FILL_W'(count_ff);
         rsp_last_ff   <= act.ctl.last_end ? flags.at_end : 1'b1;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tlast  = rsp_last_ff;
   assign rsp_tdata  = {{(slsd_pkg::RSP_DATA_W - slsd_pkg::RSP_FIELDS_W){1'b0}},
                        rsp_fill_ff, rsp_value_ff, rsp_pos_ff, rsp_status_ff};

endmodule

@@ rtl/sequential_list_with_search_delete_top.sv @@
// Clear and insert give a single result beat; search and remove compare entries
// from index 0 until a match or the end; remove then shifts entries above it down;
// dump emits count beats, one per cycle unless the output stalls, or one status
// beat when the list is empty. One command at a time: a new request is taken the
// cycle after the last beat is loaded.
// Synchronous reset empties the list and parks the sequencer; entries keep data.
// ----------------------------------------------------------------------------
// sequential_list_with_search_delete_top: ordered key list with search/remove
// A microcoded sequencer drives a register-file datapath holding up to
// CAPACITY unsigned keys; results leave through a registered stream output.
// ----------------------------------------------------------------------------
module sequential_list_with_search_delete_top (
   input  logic                                clock,
   input  logic                                reset,
   // request: tdata = key[31:0]; tuser = kind[2:0]
   input  logic                                req_tvalid,
   output logic                                req_tready,
   input  logic [slsd_pkg::KEY_W-1:0]          req_tdata,
   input  logic [slsd_pkg::KIND_W-1:0]         req_tuser,
   // response: tdata = status[1:0], position[4:2], entry_value[36:5],
   //           fill_count[40:37], zero pad[47:41]; tlast = last
   output logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   output logic [slsd_pkg::RSP_DATA_W-1:0]     rsp_tdata,
   output logic                                rsp_tlast
);

   slsd_pkg::act_type   act;
   slsd_pkg::flags_type flags;

   slsd_sequencer u_seq (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_kind   (req_tuser),
      .flags      (flags),
      .req_ready  (req_tready),
      .act        (act)
   );

   slsd_datapath u_dp (
      .clock      (clock),
      .reset      (reset),
      .act        (act),
      .req_kind   (req_tuser),
      .req_key    (req_tdata),
      .rsp_tready (rsp_tready),
      .flags      (flags),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast)
   );

endmodule
